// ===== hw/rtl/pfn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfn_pkg
// Shared widths, state and micro-op codes for the polygon face normal block.
// ----------------------------------------------------------------------------
package pfn_pkg;

  // port field widths
  localparam int FIELD_W   = 16;
  localparam int EPS_W     = 6;
  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(40);

  // number formats
  localparam int COORD_BITS       = 16;
  localparam int NORMAL_FRAC_BITS = 14;

  // derived datapath widths
  localparam int EW  = COORD_BITS + 1;         // edge component, signed
  localparam int CW  = 2 * COORD_BITS + 3;     // cross component, signed
  localparam int LW  = 2 * COORD_BITS + 2;     // squared edge length
  localparam int MW  = CW;                     // multiplier operand, signed
  localparam int PW  = 2 * MW;                 // multiplier product
  localparam int SW  = 2 * LW;                 // squared cross length
  localparam int QW  = NORMAL_FRAC_BITS + 1;   // normal magnitude
  localparam int DW  = NORMAL_FRAC_BITS + 2;   // 2q-1
  localparam int D2W = 2 * QW;                 // (2q-1)^2
  localparam int AW  = SW + D2W;               // rounding compare
  localparam int STEP_W    = 5;
  // test step, taken once the last squared cross term has landed in s
  localparam logic [STEP_W-1:0] STEP_TEST = STEP_W'(17);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_NORM,
    ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    PH_C2,
    PH_CHK,
    PH_W1,
    PH_MLO,
    PH_MHI,
    PH_W2,
    PH_CMP
  } phase_e;

  // what to do with the product in the cycle after issue
  typedef enum logic [3:0] {
    TG_NONE,
    TG_L1,
    TG_L2,
    TG_XP,
    TG_XN,
    TG_SQ,
    TG_LP,
    TG_C2,
    TG_D2,
    TG_LO,
    TG_HI
  } tag_e;

endpackage

// ===== hw/rtl/pfn_vertex_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfn_vertex_if
// Valid/ready channel carrying one polygon vertex per item.
// ----------------------------------------------------------------------------
interface pfn_vertex_if
  import pfn_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] vertex_x;
  logic signed [FIELD_W-1:0] vertex_y;
  logic signed [FIELD_W-1:0] vertex_z;
  logic                      last_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

// ===== hw/rtl/pfn_normal_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfn_normal_if
// Valid/ready channel carrying one unit normal result per item.
// ----------------------------------------------------------------------------
interface pfn_normal_if
  import pfn_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] normal_x;
  logic signed [FIELD_W-1:0] normal_y;
  logic signed [FIELD_W-1:0] normal_z;
  logic                      found;

  modport source (output valid, normal_x, normal_y, normal_z, found, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, found, output ready);
endinterface

// ===== hw/rtl/polygon_face_normal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_face_normal
// Unit normal of a polygon from its first nondegenerate fan triangle.
// ----------------------------------------------------------------------------
// Vertices enter one per item; the item flagged last_vertex produces one
// result (Q2.14 normal and found flag), all others produce none. The first
// two vertices of a polygon, and every vertex after a normal has been found,
// are only registered. A vertex that tests a new triangle runs a sequencer
// over one shared signed multiplier, which does all the multiplication:
// 18 steps for edge lengths, cross product and threshold test, then, only
// when the triangle qualifies, a binary search of at most 15 steps per
// normal component with three multiplier passes each. The block takes no
// new vertex while busy or while a result waits.
// ----------------------------------------------------------------------------
module polygon_face_normal
  import pfn_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [EPS_W-1:0] cfg_wdata_i,
  pfn_vertex_if.sink       vtx_i,
  pfn_normal_if.source     nrm_o
);

  state_e state_q, state_d;
  phase_e ph_q, ph_d;

  logic [EPS_W-1:0]  eps_q;
  logic [1:0]        count_q;
  logic              found_q;
  logic              last_q;
  logic [STEP_W-1:0] step_q;
  logic [1:0]        comp_q;

  logic signed [FIELD_W-1:0] first_q [3];
  logic signed [FIELD_W-1:0] prev_q  [3];
  logic signed [FIELD_W-1:0] held_q  [3];
  logic signed [EW-1:0]      e1_q    [3];
  logic signed [EW-1:0]      e2_q    [3];
  logic signed [CW-1:0]      c_q     [3];

  logic [LW-1:0]       l1_q, l2_q;
  logic [SW-1:0]       s_q, lp_q, c2_q;
  logic signed [PW-1:0] xtmp_q, prod_q;
  logic [D2W-1:0]      d2_q;
  logic [AW-1:0]       acc_q;
  logic [QW-1:0]       lo_q, hi_q, mid_q;

  tag_e       tag_q, mul_tag;
  logic [1:0] tidx_q, mul_idx;
  logic signed [MW-1:0] mul_a, mul_b;

  logic out_valid_q;
  logic signed [FIELD_W-1:0] out_x_q, out_y_q, out_z_q;
  logic out_found_q;

  logic in_fire, start, pass, emit, lt_done;
  logic [QW:0]   span;
  logic [QW-1:0] mid;
  logic [DW-1:0] dval;
  logic signed [CW-1:0] cur_c;

  assign vtx_i.ready = (state_q == ST_IDLE) && !out_valid_q;
  assign in_fire     = vtx_i.valid && vtx_i.ready;
  assign start       = in_fire && (count_q == 2'd2) && !found_q;
  assign pass        = (l1_q != '0) && (l2_q != '0) && (s_q > (lp_q >> eps_q));
  assign emit        = (in_fire && !start && vtx_i.last_vertex)
                    || (state_q == ST_FIN && last_q);

  // binary search midpoint
  assign span    = (QW + 1)'(hi_q) - (QW + 1)'(lo_q) + (QW + 1)'(1);
  assign mid     = lo_q + QW'(span >> 1);
  assign dval    = {mid, 1'b0} - DW'(1);
  assign cur_c   = c_q[comp_q];
  assign lt_done = lo_q >= hi_q;

  // next state
  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_CALC;
      end
      ST_CALC: begin
        if (step_q == STEP_TEST) begin
          state_d = pass ? ST_NORM : ST_FIN;
          ph_d    = PH_C2;
        end
      end
      ST_NORM: begin
        unique case (ph_q)
          PH_C2:  ph_d = PH_CHK;
          PH_CHK: begin
            if (!lt_done) ph_d = PH_W1;
            else begin
              ph_d = PH_C2;
              if (comp_q == 2'd2) state_d = ST_FIN;
            end
          end
          PH_W1:  ph_d = PH_MLO;
          PH_MLO: ph_d = PH_MHI;
          PH_MHI: ph_d = PH_W2;
          PH_W2:  ph_d = PH_CMP;
          PH_CMP: ph_d = PH_CHK;
          default: ph_d = PH_C2;
        endcase
      end
      ST_FIN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_tag = TG_NONE;
    mul_idx = 2'd0;
    if (state_q == ST_CALC) begin
      unique case (step_q)
        5'd0, 5'd1, 5'd2: begin
          mul_a = MW'(e1_q[step_q[1:0]]); mul_b = mul_a; mul_tag = TG_L1;
        end
        5'd3: begin mul_a = MW'(e2_q[0]); mul_b = mul_a; mul_tag = TG_L2; end
        5'd4: begin mul_a = MW'(e2_q[1]); mul_b = mul_a; mul_tag = TG_L2; end
        5'd5: begin mul_a = MW'(e2_q[2]); mul_b = mul_a; mul_tag = TG_L2; end
        5'd6: begin mul_a = MW'(e1_q[1]); mul_b = MW'(e2_q[2]); mul_tag = TG_XP; end
        5'd7: begin
          mul_a = MW'(e1_q[2]); mul_b = MW'(e2_q[1]); mul_tag = TG_XN; mul_idx = 2'd0;
        end
        5'd8: begin mul_a = MW'(e1_q[2]); mul_b = MW'(e2_q[0]); mul_tag = TG_XP; end
        5'd9: begin
          mul_a = MW'(e1_q[0]); mul_b = MW'(e2_q[2]); mul_tag = TG_XN; mul_idx = 2'd1;
        end
        5'd10: begin mul_a = MW'(e1_q[0]); mul_b = MW'(e2_q[1]); mul_tag = TG_XP; end
        5'd11: begin
          mul_a = MW'(e1_q[1]); mul_b = MW'(e2_q[0]); mul_tag = TG_XN; mul_idx = 2'd2;
        end
        5'd12: begin
          mul_a = signed'(MW'(l1_q)); mul_b = signed'(MW'(l2_q)); mul_tag = TG_LP;
        end
        5'd13: begin mul_a = c_q[0]; mul_b = c_q[0]; mul_tag = TG_SQ; end
        5'd14: begin mul_a = c_q[1]; mul_b = c_q[1]; mul_tag = TG_SQ; end
        5'd15: begin mul_a = c_q[2]; mul_b = c_q[2]; mul_tag = TG_SQ; end
        default: mul_tag = TG_NONE;
      endcase
    end else if (state_q == ST_NORM) begin
      priority case (ph_q)
        PH_C2: begin mul_a = cur_c; mul_b = cur_c; mul_tag = TG_C2; end
        PH_CHK: begin
          if (!lt_done) begin
            mul_a = signed'(MW'(dval)); mul_b = mul_a; mul_tag = TG_D2;
          end
        end
        PH_MLO: begin
          mul_a = signed'(MW'(d2_q)); mul_b = signed'(MW'(s_q[LW-1:0])); mul_tag = TG_LO;
        end
        PH_MHI: begin
          mul_a = signed'(MW'(d2_q)); mul_b = signed'(MW'(s_q[SW-1:LW])); mul_tag = TG_HI;
        end
        default: mul_tag = TG_NONE;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= PH_C2;
      eps_q       <= EPS_RESET;
      count_q     <= 2'd0;
      found_q     <= 1'b0;
      last_q      <= 1'b0;
      step_q      <= '0;
      comp_q      <= 2'd0;
      tag_q       <= TG_NONE;
      tidx_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      tag_q   <= mul_tag;
      tidx_q  <= mul_idx;
      if (cfg_we_i) eps_q <= cfg_wdata_i;
      if (emit) out_valid_q <= 1'b1;
      else if (nrm_o.ready) out_valid_q <= 1'b0;
      if (in_fire) last_q <= vtx_i.last_vertex;
      if (emit) count_q <= 2'd0;
      else if (in_fire && count_q != 2'd2) count_q <= count_q + 2'd1;
      step_q <= (state_q == ST_CALC) ? step_q + STEP_W'(1) : '0;
      if (state_q == ST_CALC) comp_q <= 2'd0;
      else if (state_q == ST_NORM && ph_q == PH_CHK && lt_done) comp_q <= comp_q + 2'd1;
      if (emit) found_q <= 1'b0;
      else if (state_q == ST_NORM && ph_q == PH_CHK && lt_done && comp_q == 2'd2) begin
        found_q <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_fire) begin
      if (count_q == 2'd0) begin
        first_q[0] <= vtx_i.vertex_x;
        first_q[1] <= vtx_i.vertex_y;
        first_q[2] <= vtx_i.vertex_z;
      end
      prev_q[0] <= vtx_i.vertex_x;
      prev_q[1] <= vtx_i.vertex_y;
      prev_q[2] <= vtx_i.vertex_z;
      e1_q[0] <= EW'(prev_q[0]) - EW'(first_q[0]);
      e1_q[1] <= EW'(prev_q[1]) - EW'(first_q[1]);
      e1_q[2] <= EW'(prev_q[2]) - EW'(first_q[2]);
      e2_q[0] <= EW'(vtx_i.vertex_x) - EW'(first_q[0]);
      e2_q[1] <= EW'(vtx_i.vertex_y) - EW'(first_q[1]);
      e2_q[2] <= EW'(vtx_i.vertex_z) - EW'(first_q[2]);
      l1_q <= '0;
      l2_q <= '0;
      s_q  <= '0;
    end
    // consume the product issued last cycle
    unique case (tag_q)
      TG_L1: l1_q <= l1_q + LW'(prod_q);
      TG_L2: l2_q <= l2_q + LW'(prod_q);
      TG_XP: xtmp_q <= prod_q;
      TG_XN: c_q[tidx_q] <= CW'(xtmp_q - prod_q);
      TG_SQ: s_q <= s_q + SW'(prod_q);
      TG_LP: lp_q <= SW'(prod_q);
      TG_C2: c2_q <= SW'(prod_q);
      TG_D2: d2_q <= D2W'(prod_q);
      TG_LO: acc_q <= AW'(prod_q);
      TG_HI: acc_q <= acc_q + (AW'(prod_q) << LW);
      default: ;
    endcase
    // rounding search over one component
    if (state_q == ST_NORM) begin
      priority case (ph_q)
        PH_C2: begin
          lo_q <= '0;
          hi_q <= QW'(1) << NORMAL_FRAC_BITS;
        end
        PH_CHK: begin
          mid_q <= mid;
          if (lt_done) begin
            held_q[comp_q] <= cur_c[CW-1] ? -FIELD_W'(lo_q) : FIELD_W'(lo_q);
          end
        end
        PH_CMP: begin
          if (acc_q <= (AW'(c2_q) << (2 * NORMAL_FRAC_BITS + 2))) lo_q <= mid_q;
          else hi_q <= mid_q - QW'(1);
        end
        default: ;
      endcase
    end
    // result register
    if (emit) begin
      out_x_q     <= found_q ? held_q[0] : '0;
      out_y_q     <= found_q ? held_q[1] : '0;
      out_z_q     <= found_q ? held_q[2] : '0;
      out_found_q <= found_q;
    end
  end

  assign nrm_o.valid    = out_valid_q;
  assign nrm_o.normal_x = out_x_q;
  assign nrm_o.normal_y = out_y_q;
  assign nrm_o.normal_z = out_z_q;
  assign nrm_o.found    = out_found_q;

endmodule
